### rtl/assert_macros.svh
// assertion macros used by the checker file hll_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is held
`define HLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define HLL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hll_pkg.sv
// ----------------------------------------------------------------------------
// hll_pkg
// shared constants, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int INDEX_BITS_DEF = 8;
    localparam int HASH_W         = 32;
    localparam int RANK_W         = 5;
    localparam int EST_W          = 40;
    localparam int FRAC_W         = 24;
    localparam int LOG_IN_W       = 41;
    localparam int LOG_W          = 30;
    localparam int LN_W           = 30;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic add_rd;
        logic add_wr;
        logic scan_start;
        logic scan_step;
        logic clr_start;
        logic clr_step;
        logic div_start;
        logic div_step;
        logic div_end;
        logic log_start;
        logic log_src_d;
        logic lc_d;
        logic lr_d;
        logic ln_calc;
        logic lc_fin;
        logic lr_fin;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic div_done;
        logic log_busy;
        logic lc_ok;
        logic big;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/hll_ctrl.sv
// ----------------------------------------------------------------------------
// hll_ctrl
// request sequencer: issues datapath commands for add, query and clear
// ----------------------------------------------------------------------------
module hll_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_req,
    output logic               in_ready,
    input  hll_pkg::dp_stat_t  stat,
    output hll_pkg::dp_cmd_t   cmd
);

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_ADD_RD  = 5'd2;
    localparam logic [4:0] S_ADD_WR  = 5'd3;
    localparam logic [4:0] S_SCAN_ST = 5'd4;
    localparam logic [4:0] S_SCAN    = 5'd5;
    localparam logic [4:0] S_DIV_ST  = 5'd6;
    localparam logic [4:0] S_DIV     = 5'd7;
    localparam logic [4:0] S_DIV_END = 5'd8;
    localparam logic [4:0] S_LC_CHK  = 5'd9;
    localparam logic [4:0] S_LC_LOG  = 5'd10;
    localparam logic [4:0] S_LC_LN   = 5'd11;
    localparam logic [4:0] S_LC_FIN  = 5'd12;
    localparam logic [4:0] S_LR_CHK  = 5'd13;
    localparam logic [4:0] S_LR_LOG  = 5'd14;
    localparam logic [4:0] S_LR_LN   = 5'd15;
    localparam logic [4:0] S_LR_FIN  = 5'd16;
    localparam logic [4:0] S_CLR_ST  = 5'd17;
    localparam logic [4:0] S_CLR     = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                // clearing pass over the rank memory after reset
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_req)
                        hll_pkg::REQ_ADD:   state_next = S_ADD_RD;
                        hll_pkg::REQ_QUERY: state_next = S_SCAN_ST;
                        hll_pkg::REQ_CLEAR: state_next = S_CLR_ST;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_RD:
            begin
                cmd.add_rd = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN_ST:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DIV_ST;
                end
            end
            S_DIV_ST:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_LC_CHK;
            end
            S_LC_CHK:
            begin
                if (stat.lc_ok)
                begin
                    cmd.log_start = 1'b1;
                    state_next    = S_LC_LOG;
                end
                else
                begin
                    state_next = S_LR_CHK;
                end
            end
            S_LC_LOG:
            begin
                if (!stat.log_busy)
                begin
                    cmd.lc_d   = 1'b1;
                    state_next = S_LC_LN;
                end
            end
            S_LC_LN:
            begin
                cmd.ln_calc = 1'b1;
                state_next  = S_LC_FIN;
            end
            S_LC_FIN:
            begin
                cmd.lc_fin = 1'b1;
                state_next = S_LR_CHK;
            end
            S_LR_CHK:
            begin
                if (stat.big)
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_src_d = 1'b1;
                    state_next    = S_LR_LOG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LR_LOG:
            begin
                if (!stat.log_busy)
                begin
                    cmd.lr_d   = 1'b1;
                    state_next = S_LR_LN;
                end
            end
            S_LR_LN:
            begin
                cmd.ln_calc = 1'b1;
                state_next  = S_LR_FIN;
            end
            S_LR_FIN:
            begin
                cmd.lr_fin = 1'b1;
                state_next = S_DONE;
            end
            S_CLR_ST:
            begin
                cmd.clr_start = 1'b1;
                state_next    = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/hll_log2.sv
// ----------------------------------------------------------------------------
// hll_log2
// iterative log2 in Q.24: one-bit normalising shift per cycle, then one
// squaring round per fraction bit
// ----------------------------------------------------------------------------
module hll_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hll_pkg::LOG_IN_W-1:0]  x,
    output logic                          busy,
    output logic [hll_pkg::LOG_W-1:0]     result
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;

    localparam int NW = hll_pkg::LOG_W - hll_pkg::FRAC_W;

    logic [1:0]                        state_reg;
    logic [hll_pkg::LOG_IN_W-1:0]      xs_reg;
    logic [NW-1:0]                     n_reg;
    logic [31:0]                       y_reg;
    logic [hll_pkg::FRAC_W-1:0]        frac_reg;
    logic [4:0]                        cnt_reg;
    logic [63:0]                       sq;
    logic [32:0]                       sq_top;

    assign sq     = 64'(y_reg) * 64'(y_reg);
    assign sq_top = sq[63:31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (xs_reg[hll_pkg::LOG_IN_W-1])
                    begin
                        state_reg <= L_SQ;
                        cnt_reg   <= '0;
                    end
                end
                L_SQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(hll_pkg::FRAC_W - 1))
                    begin
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    // zero is taken as one
                    xs_reg <= (x == '0) ? hll_pkg::LOG_IN_W'(1) : x;
                    n_reg  <= NW'(hll_pkg::LOG_IN_W - 1);
                end
            end
            L_NORM:
            begin
                if (xs_reg[hll_pkg::LOG_IN_W-1])
                begin
                    // mantissa as Q1.31, low bits dropped
                    y_reg    <= xs_reg[hll_pkg::LOG_IN_W-1 -: 32];
                    frac_reg <= '0;
                end
                else
                begin
                    xs_reg <= {xs_reg[hll_pkg::LOG_IN_W-2:0], 1'b0};
                    n_reg  <= n_reg - NW'(1);
                end
            end
            L_SQ:
            begin
                frac_reg <= {frac_reg[hll_pkg::FRAC_W-2:0], sq_top[32]};
                y_reg    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            end
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
    end

    assign busy   = (state_reg != L_IDLE);
    assign result = {n_reg, frac_reg};

endmodule

### rtl/hll_dp.sv
// ----------------------------------------------------------------------------
// hll_dp
// rank memory, register scan, restoring divider, log/ln stages and the
// output register
// ----------------------------------------------------------------------------
module hll_dp #(
    parameter int INDEX_BITS = hll_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hll_pkg::dp_cmd_t              cmd,
    output hll_pkg::dp_stat_t             stat,
    input  logic [hll_pkg::HASH_W-1:0]    hash_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hll_pkg::EST_W-1:0]     out_est,
    output logic                          out_sat
);

    localparam int M    = 1 << INDEX_BITS;
    localparam int W    = hll_pkg::HASH_W - INDEX_BITS;
    localparam int SUMW = 33 + INDEX_BITS;
    localparam int NUMW = 40 + 2 * INDEX_BITS;
    localparam int CNTW = $clog2(NUMW + 1);
    localparam int EW   = hll_pkg::EST_W;
    localparam int RW   = hll_pkg::RANK_W;

    localparam longint unsigned DEN_A = 64'd10 * (64'd1000 * 64'(M) + 64'd1079);
    localparam longint unsigned ALPHA64 =
        (M == 16) ? ((64'd673 << 24) + 64'd500) / 64'd1000 :
        (M == 32) ? ((64'd697 << 24) + 64'd500) / 64'd1000 :
        (M == 64) ? ((64'd709 << 24) + 64'd500) / 64'd1000 :
        (((64'd7213 * 64'(M)) << 24) + DEN_A / 64'd2) / DEN_A;
    localparam logic [NUMW-1:0] ALPHA   = NUMW'(ALPHA64);
    localparam logic [NUMW-1:0] NUM     = ALPHA << (2 * INDEX_BITS + 16);
    localparam logic [EW-1:0]   LC_LIM  = EW'(640) << INDEX_BITS;
    localparam logic [hll_pkg::LOG_W-1:0] LC_K =
        hll_pkg::LOG_W'(INDEX_BITS) << hll_pkg::FRAC_W;
    localparam logic [hll_pkg::LOG_W-1:0] LR_K =
        hll_pkg::LOG_W'(40) << hll_pkg::FRAC_W;

    logic [RW-1:0]                 rank_mem [M];
    logic [RW-1:0]                 rd_data_reg;
    logic [hll_pkg::HASH_W-1:0]    hash_reg;
    logic [INDEX_BITS:0]           idx_reg;
    logic                          rd_vld_reg;
    logic [SUMW-1:0]               sum_reg;
    logic [INDEX_BITS:0]           zeros_reg;
    logic [SUMW-1:0]               rem_reg;
    logic [NUMW-1:0]               num_reg;
    logic [EW-1:0]                 q_reg;
    logic [CNTW-1:0]               div_cnt_reg;
    logic [EW-1:0]                 e_reg;
    logic                          sat_reg;
    logic [hll_pkg::LOG_W-1:0]     d_reg;
    logic [hll_pkg::LN_W-1:0]      ln_reg;
    logic                          out_valid_reg;
    logic [EW-1:0]                 out_est_reg;
    logic                          out_sat_reg;

    logic [INDEX_BITS-1:0]         hash_idx;
    logic [W-1:0]                  rest;
    logic [RW-1:0]                 rank_new;
    logic [INDEX_BITS-1:0]         rd_addr;
    logic [INDEX_BITS-1:0]         wr_addr;
    logic [RW-1:0]                 wr_data;
    logic                          wr_en;
    logic [SUMW-1:0]               term;
    logic [SUMW:0]                 trial;
    logic                          ge;
    logic [SUMW:0]                 rem_next;
    logic [hll_pkg::LOG_IN_W-1:0]  log_x;
    logic                          log_busy;
    logic [hll_pkg::LOG_W-1:0]     log_res;
    logic [hll_pkg::LOG_W+31:0]    ln_prod;
    logic [EW+15:0]                lc_wide;
    logic [EW+4:0]                 e30;

    assign hash_idx = hash_reg[hll_pkg::HASH_W-1 -: INDEX_BITS];
    assign rest     = hash_reg[W-1:0];

    // rank: one plus leading zeros of the low bits, full width when all zero
    always_comb
    begin
        rank_new = RW'(W);
        for (int i = 0; i < W; i++)
        begin
            if (rest[i])
            begin
                rank_new = RW'(W - i);
            end
        end
    end

    assign rd_addr = cmd.add_rd ? hash_idx : idx_reg[INDEX_BITS-1:0];
    assign wr_addr = cmd.add_wr ? hash_idx : idx_reg[INDEX_BITS-1:0];
    assign wr_data = cmd.add_wr ? rank_new : '0;
    assign wr_en   = (cmd.add_wr && (rank_new > rd_data_reg))
                   || (cmd.clr_step && !idx_reg[INDEX_BITS]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rank_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= rank_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_start || cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if ((cmd.clr_step || cmd.scan_step) && !idx_reg[INDEX_BITS])
            begin
                idx_reg <= idx_reg + (INDEX_BITS+1)'(1);
            end
            rd_vld_reg <= cmd.scan_step && !idx_reg[INDEX_BITS];
        end
    end

    assign term = SUMW'(1) << (6'd32 - {1'b0, rd_data_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hash_reg <= hash_in;
        end
        if (cmd.scan_start)
        begin
            sum_reg   <= '0;
            zeros_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            sum_reg   <= sum_reg + term;
            zeros_reg <= zeros_reg + (INDEX_BITS+1)'(rd_data_reg == '0);
        end
    end

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, num_reg[NUMW-1]};
    assign ge       = (trial >= {1'b0, sum_reg});
    assign rem_next = ge ? (trial - {1'b0, sum_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step && !stat.div_done)
        begin
            div_cnt_reg <= div_cnt_reg + CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            num_reg <= NUM;
            q_reg   <= '0;
        end
        else if (cmd.div_step && !stat.div_done)
        begin
            rem_reg <= rem_next[SUMW-1:0];
            num_reg <= {num_reg[NUMW-2:0], 1'b0};
            q_reg   <= {q_reg[EW-2:0], ge};
        end
    end

    assign log_x = cmd.log_src_d
                 ? ((hll_pkg::LOG_IN_W'(1) << 40) - {1'b0, e_reg})
                 : hll_pkg::LOG_IN_W'(zeros_reg);

    hll_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .x      (log_x),
        .busy   (log_busy),
        .result (log_res)
    );

    assign ln_prod = d_reg * hll_pkg::LN2_Q32;
    assign lc_wide = (EW+16)'(ln_reg) << INDEX_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.lc_d)
        begin
            d_reg <= LC_K - log_res;
        end
        else if (cmd.lr_d)
        begin
            d_reg <= LR_K - log_res;
        end
        if (cmd.ln_calc)
        begin
            ln_reg <= ln_prod[hll_pkg::LOG_W+31:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.div_end)
        begin
            e_reg <= q_reg;
        end
        else if (cmd.lc_fin)
        begin
            e_reg <= lc_wide[EW+15:16];
        end
        else if (cmd.lr_fin)
        begin
            if (ln_reg[hll_pkg::LN_W-1:hll_pkg::FRAC_W] != '0)
            begin
                e_reg   <= '1;
                sat_reg <= 1'b1;
            end
            else
            begin
                e_reg <= {ln_reg[hll_pkg::FRAC_W-1:0], 16'b0};
            end
        end
    end

    assign e30 = ({5'b0, e_reg} << 5) - ({5'b0, e_reg} << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_est_reg <= e_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign stat.clr_done  = idx_reg[INDEX_BITS];
    assign stat.scan_done = idx_reg[INDEX_BITS] && !rd_vld_reg;
    assign stat.div_done  = (div_cnt_reg == CNTW'(NUMW));
    assign stat.log_busy  = log_busy;
    assign stat.lc_ok     = (e_reg <= LC_LIM) && (zeros_reg != '0);
    assign stat.big       = (e30 > ((EW+5)'(1) << 40));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_est   = out_est_reg;
    assign out_sat   = out_sat_reg;

endmodule

### rtl/hyperloglog_cardinality_sketch.sv
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_sketch
// hyperloglog sketch with 2^INDEX_BITS rank registers and fixed-point query
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the s_ stream: s_tuser holds the request kind (add,
//   query, clear, anything else is a no-op), s_tdata the 32-bit hash.
//   every request gives exactly one result item on the m_ stream: m_tdata
//   holds the Q32.8 estimate for a query and zero otherwise, m_tuser flags
//   a clamped estimate.
//   one request is in work at a time; s_tready is high only while idle.
//   add: memory read, then compare and write, from accept to result.
//   clear: one memory entry written per cycle.
//   query: a scan and the divider (one register read and one quotient bit
//   per cycle), plus one log2 pass (normalising shift and 24 squaring
//   rounds) for each small or large range correction that applies.
//   after reset a clearing pass over the rank memory runs before the
//   first request is taken.
//   a finished result sits in the output register; while m_tready is low
//   the next request is still taken and worked on, and only its result
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module hyperloglog_cardinality_sketch #(
    parameter int INDEX_BITS = hll_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] hash_value
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [39:0] estimate
    output logic        m_tuser     // [0] saturated
);

    hll_pkg::dp_cmd_t  cmd;
    hll_pkg::dp_stat_t stat;

    hll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hll_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .hash_in   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_est   (m_tdata),
        .out_sat   (m_tuser)
    );

endmodule

### rtl/hll_checker.sv
// ----------------------------------------------------------------------------
// hll_checker
// port-level checks on the sketch, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // result item holds while stalled
    `HLL_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

    // one item in work at a time
    `HLL_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")

    // a clamped estimate reads all ones
    `HLL_ASSERT(a_sat_max, (m_tvalid && m_tuser) |-> (m_tdata == 40'hFF_FFFF_FFFF), "saturated estimate not clamped")

    // clearing pass runs straight after reset
    `HLL_ASSERT(a_init_clear, $rose(rst_n) |-> (!s_tready && !m_tvalid), "items taken before clearing pass")

    // nothing shown while reset is held
    `HLL_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> (!m_tvalid && !s_tready), "handshake active in reset")

endmodule

bind hyperloglog_cardinality_sketch hll_checker u_hll_checker (.*);

### sim/hll_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hll_result_checker
// watches the request and result streams, predicts each result from its own
// copy of the rank registers and compares field by field
// ----------------------------------------------------------------------------
module hll_result_checker #(
    parameter int INDEX_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          sat_seen
);

    localparam int REGS = 1 << INDEX_BITS;
    localparam int REST = 32 - INDEX_BITS;
    localparam logic [39:0] EST_TOP = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [39:0] estimate;
        logic        saturated;
    } hll_result_t;

    logic [4:0]  rank_mem [REGS];
    hll_result_t expected_q [$];

    function automatic logic [63:0] log2_fix(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] frac;
        int          msb;
        x = (x_in == 0) ? 64'd1 : x_in;
        msb = 0;
        frac = 0;
        for (int b = 0; b < 64; b++)
            if (x[b])
                msb = b;
        if (msb >= 31)
            y = x >> (msb - 31);
        else
            y = x << (31 - msb);
        for (int i = 0; i < 24; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(msb) << 24) | frac;
    endfunction

    function automatic logic [63:0] ln_fix(input logic [63:0] l2);
        logic [127:0] p;
        p = 128'(l2) * 128'(hll_pkg::LN2_Q32);
        return p[95:32];
    endfunction

    function automatic logic [63:0] alpha_fix();
        logic [63:0] m;
        logic [63:0] den;
        m = REGS;
        if (REGS == 16)
            return ((64'd673 << 24) + 500) / 1000;
        if (REGS == 32)
            return ((64'd697 << 24) + 500) / 1000;
        if (REGS == 64)
            return ((64'd709 << 24) + 500) / 1000;
        den = 10 * (1000 * m + 1079);
        return (((64'd7213 * m) << 24) + den / 2) / den;
    endfunction

    function automatic hll_result_t estimate_now();
        hll_result_t  res;
        logic [63:0]  sum;
        logic [63:0]  zeros;
        logic [63:0]  e;
        logic [127:0] num;
        logic [63:0]  l;
        sum = 0;
        zeros = 0;
        for (int i = 0; i < REGS; i++)
        begin
            sum += 64'd1 << (32 - rank_mem[i]);
            if (rank_mem[i] == 0)
                zeros++;
        end
        num = (128'(alpha_fix()) * REGS * REGS) << 16;
        e = 64'(num / sum);
        if (e <= 640 * REGS && zeros != 0)
            e = (REGS * ln_fix((64'(INDEX_BITS) << 24) - log2_fix(zeros))) >> 16;
        res.saturated = 1'b0;
        if (e * 30 > (64'd1 << 40))
        begin
            if (e > EST_TOP)
                e = EST_TOP;
            l = ln_fix((64'd40 << 24) - log2_fix((64'd1 << 40) - e));
            if (l >= (64'd1 << 24))
            begin
                e = EST_TOP;
                res.saturated = 1'b1;
            end
            else
                e = l << 16;
        end
        res.estimate = e[39:0];
        return res;
    endfunction

    function automatic hll_result_t apply_request(input logic [1:0] kind,
                                                  input logic [31:0] hash);
        hll_result_t res;
        int          idx;
        int          rnk;
        res = '0;
        if (kind == hll_pkg::REQ_ADD)
        begin
            idx = hash >> REST;
            rnk = REST;
            for (int b = 0; b < REST; b++)
                if (hash[b])
                    rnk = REST - b;
            if (rnk > rank_mem[idx])
                rank_mem[idx] = 5'(rnk);
        end
        else if (kind == hll_pkg::REQ_QUERY)
            res = estimate_now();
        else if (kind == hll_pkg::REQ_CLEAR)
            for (int i = 0; i < REGS; i++)
                rank_mem[i] = '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hll_result_t got;
        hll_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REGS; i++)
                rank_mem[i] = '0;
            errors <= 0;
            results_seen <= 0;
            sat_seen <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.estimate = m_tdata;
                got.saturated = m_tuser;
                results_seen <= results_seen + 1;
                if (m_tuser)
                    sat_seen <= sat_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result est=%h sat=%b", $time,
                             m_tdata, m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.estimate !== want.estimate ||
                        got.saturated !== want.saturated)
                    begin
                        $display("%0t: mismatch expected est=%h sat=%b actual est=%h sat=%b",
                                 $time, want.estimate, want.saturated,
                                 got.estimate, got.saturated);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives add, query, clear and no-op requests under varied idling and
// gives the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
module testbench;

    localparam int INDEX_BITS = 8;
    localparam int LIMIT = 20000;
    localparam logic [1:0] REQ_NOP = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    int          errors;
    int          pending;
    int          results_seen;
    int          sat_seen;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          quiet_cycles;
    int          sent;

    hyperloglog_cardinality_sketch #(.INDEX_BITS(INDEX_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    hll_result_checker #(.INDEX_BITS(INDEX_BITS)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .results_seen(results_seen),
        .sat_seen(sat_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT)
        begin
            $display("hyperloglog_cardinality_sketch verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] hash);
        // the block is busy after an accept anyway
        @(posedge clk);
        while ($urandom_range(99) < src_idle_pct)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= hash;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        s_tvalid <= 1'b0;
        sent++;
    endtask

    // well-formed bursts of adds with queries, occasional clears and no-ops
    task automatic random_requests(input int count, input int spread);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_request(hll_pkg::REQ_ADD, $urandom() >> $urandom_range(spread));
            else if (pick < 93)
                send_request(hll_pkg::REQ_QUERY, $urandom());
            else if (pick < 97)
                send_request(hll_pkg::REQ_CLEAR, $urandom());
            else
                send_request(REQ_NOP, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_NOP;
        m_tready = 1'b1;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        quiet_cycles = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sketch, extremes of rank and index, no-op, clear
        send_request(hll_pkg::REQ_QUERY, 32'h0);
        send_request(hll_pkg::REQ_ADD, 32'h0000_0000);
        send_request(hll_pkg::REQ_ADD, 32'hFFFF_FFFF);
        send_request(hll_pkg::REQ_ADD, 32'h0080_0000);
        send_request(hll_pkg::REQ_ADD, 32'h7F00_0001);
        send_request(hll_pkg::REQ_QUERY, 32'hFFFF_FFFF);
        send_request(REQ_NOP, 32'hFFFF_FFFF);
        send_request(hll_pkg::REQ_QUERY, 32'h0);
        send_request(hll_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
        send_request(hll_pkg::REQ_QUERY, 32'h0);
        // every register at the top rank drives the large range correction
        for (int i = 0; i < 256; i++)
            send_request(hll_pkg::REQ_ADD, i << 24);
        send_request(hll_pkg::REQ_QUERY, 32'h0);
        send_request(hll_pkg::REQ_CLEAR, 32'h0);
        // every register at a mid rank, then a mixed fill
        for (int i = 0; i < 256; i++)
            send_request(hll_pkg::REQ_ADD, (i << 24) | (32'h1 << $urandom_range(4, 9)));
        send_request(hll_pkg::REQ_QUERY, 32'h0);
        send_request(hll_pkg::REQ_CLEAR, 32'h0);

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1 || ph == 3) ? 77 : 0;
            sink_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 23 : 0;
            if (ph == 3)
                src_idle_pct = 23;
            random_requests(300, 24);
            random_requests(60, 0);
        end
        sink_stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("requests sent: %0d, results checked: %0d, clamped estimates: %0d",
                 sent, results_seen, sat_seen);
        $display("phases: no idling, sender idle, receiver stalling, both");
        if (errors == 0 && pending == 0)
            $display("hyperloglog_cardinality_sketch verification clean");
        else
            $display("hyperloglog_cardinality_sketch verification failed");
        $finish;
    end
endmodule
